// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of the buffer pool core.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, ignored while reset is active.
`define BPM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, also checked during reset.
`define BPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bpm_pkg.sv
// Shared types and constants for the buffer pool manager core.
// Used by the controller, the datapath, the top level and the checker.
package bpm_pkg;

	// Pool size and the widths that follow from it.
	localparam int NUM_BUFFERS = 4;
	localparam int IDX_W       = $clog2(NUM_BUFFERS);
	localparam int LVL_W       = $clog2(NUM_BUFFERS + 1);
	localparam int SUM_W       = LVL_W + 1;

	// Fixed widths of the transaction fields.
	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 3;

	// Operation codes.
	typedef enum logic [OPCODE_W-1:0] {
		OP_GRAB    = 2'd0,
		OP_QUEUE   = 2'd1,
		OP_TAKE    = 2'd2,
		OP_RELEASE = 2'd3
	} opcode_t;

	// Result status codes.
	localparam logic [STATUS_W-1:0] RES_OK            = 3'd0;
	localparam logic [STATUS_W-1:0] RES_FREE_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] RES_RANGE         = 3'd2;
	localparam logic [STATUS_W-1:0] RES_WRONG_STATE   = 3'd3;
	localparam logic [STATUS_W-1:0] RES_PENDING_EMPTY = 3'd4;

	// Per-buffer ownership state.
	typedef enum logic [1:0] {
		BUF_FREE    = 2'd0,
		BUF_GRABBED = 2'd1,
		BUF_PENDING = 2'd2
	} bstate_t;

	// Request transaction.
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [INDEX_W-1:0]  buf_id;
	} req_t;

	// Response transaction.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  result_index;
		logic [COUNT_W-1:0]  free_count;
		logic [COUNT_W-1:0]  pending_count;
		logic [COUNT_W-1:0]  min_free_seen;
		logic [COUNT_W-1:0]  max_pending_seen;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

endpackage

// File: rtl/core/bpm_ctrl.sv
// Controller of the buffer pool manager: request capture, execution and response valid.
// Depends on bpm_pkg for the command struct.
module bpm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output bpm_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} fsm_state_t;

	fsm_state_t state_q;
	fsm_state_t state_nx;
	logic       rsp_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_nx   = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				// Execute only once the response register is free or being emptied.
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register and response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/core/bpm_datapath.sv
// Datapath of the buffer pool manager: free and pending FIFOs, buffer state table,
// level and watermark registers, request and response registers. Depends on bpm_pkg.
module bpm_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  bpm_pkg::ctrl_cmd_t cmd,
	input  bpm_pkg::req_t      req,
	output bpm_pkg::rsp_t      rsp
);

	localparam int N     = bpm_pkg::NUM_BUFFERS;
	localparam int IDX_W = bpm_pkg::IDX_W;
	localparam int LVL_W = bpm_pkg::LVL_W;
	localparam int SUM_W = bpm_pkg::SUM_W;

	// Ring position: pointer plus offset, wrapped once into the pool size.
	function automatic logic [IDX_W-1:0] wrap_add(
		input logic [IDX_W-1:0] ptr,
		input logic [LVL_W-1:0] ofs
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(ptr) + SUM_W'(ofs);
		if (sum >= SUM_W'(N)) begin
			sum = sum - SUM_W'(N);
		end
		return sum[IDX_W-1:0];
	endfunction

	bpm_pkg::req_t    req_q;
	bpm_pkg::rsp_t    rsp_q;
	logic [IDX_W-1:0] free_mem_q [N];
	logic [IDX_W-1:0] pend_mem_q [N];
	bpm_pkg::bstate_t state_q    [N];
	logic [IDX_W-1:0] free_rd_q;
	logic [IDX_W-1:0] pend_rd_q;
	logic [LVL_W-1:0] free_lvl_q;
	logic [LVL_W-1:0] pend_lvl_q;
	logic [LVL_W-1:0] low_q;
	logic [LVL_W-1:0] high_q;

	logic [IDX_W-1:0]            free_head;
	logic [IDX_W-1:0]            pend_head;
	logic [IDX_W-1:0]            idx_low;
	logic [IDX_W-1:0]            st_addr;
	bpm_pkg::bstate_t            st_rd;
	logic                        idx_ok;
	logic                        free_head_ok;
	logic                        pend_head_ok;
	logic                        do_grab;
	logic                        do_queue;
	logic                        do_take;
	logic                        do_release;
	logic [bpm_pkg::STATUS_W-1:0] status;
	logic [bpm_pkg::INDEX_W-1:0]  rindex;
	logic [LVL_W-1:0]            free_lvl_nx;
	logic [LVL_W-1:0]            pend_lvl_nx;
	logic [LVL_W-1:0]            low_nx;
	logic [LVL_W-1:0]            high_nx;

	// Decode the operation and check it against the FIFOs and the state table.
	always_comb begin
		free_head    = free_mem_q[free_rd_q];
		pend_head    = pend_mem_q[pend_rd_q];
		idx_low      = req_q.buf_id[IDX_W-1:0];
		idx_ok       = ({1'b0, req_q.buf_id} < (bpm_pkg::INDEX_W + 1)'(N));
		free_head_ok = ((IDX_W + 1)'(free_head) < (IDX_W + 1)'(N));
		pend_head_ok = ((IDX_W + 1)'(pend_head) < (IDX_W + 1)'(N));

		case (req_q.opcode)
			bpm_pkg::OP_GRAB: st_addr = free_head;
			bpm_pkg::OP_TAKE: st_addr = pend_head;
			default:          st_addr = idx_low;
		endcase
		st_rd = state_q[st_addr];

		status     = bpm_pkg::RES_OK;
		rindex     = '0;
		do_grab    = 1'b0;
		do_queue   = 1'b0;
		do_take    = 1'b0;
		do_release = 1'b0;

		case (req_q.opcode)
			bpm_pkg::OP_GRAB: begin
				if (free_lvl_q == '0) begin
					status = bpm_pkg::RES_FREE_EMPTY;
				end else begin
					rindex = bpm_pkg::INDEX_W'(free_head);
					if (!free_head_ok || st_rd != bpm_pkg::BUF_FREE) begin
						status = bpm_pkg::RES_WRONG_STATE;
					end else begin
						do_grab = 1'b1;
					end
				end
			end
			bpm_pkg::OP_QUEUE: begin
				rindex = req_q.buf_id;
				if (!idx_ok) begin
					status = bpm_pkg::RES_RANGE;
				end else if (st_rd != bpm_pkg::BUF_GRABBED || pend_lvl_q >= LVL_W'(N)) begin
					status = bpm_pkg::RES_WRONG_STATE;
				end else begin
					do_queue = 1'b1;
				end
			end
			bpm_pkg::OP_TAKE: begin
				if (pend_lvl_q == '0) begin
					status = bpm_pkg::RES_PENDING_EMPTY;
				end else begin
					rindex = bpm_pkg::INDEX_W'(pend_head);
					if (!pend_head_ok || st_rd != bpm_pkg::BUF_PENDING) begin
						status = bpm_pkg::RES_WRONG_STATE;
					end else begin
						do_take = 1'b1;
					end
				end
			end
			bpm_pkg::OP_RELEASE: begin
				rindex = req_q.buf_id;
				if (!idx_ok) begin
					status = bpm_pkg::RES_RANGE;
				end else if (st_rd != bpm_pkg::BUF_PENDING || free_lvl_q >= LVL_W'(N)) begin
					status = bpm_pkg::RES_WRONG_STATE;
				end else begin
					do_release = 1'b1;
				end
			end
			default: begin
				status = bpm_pkg::RES_WRONG_STATE;
			end
		endcase
	end

	// Levels and watermarks after the operation.
	always_comb begin
		free_lvl_nx = free_lvl_q;
		pend_lvl_nx = pend_lvl_q;
		if (do_grab) begin
			free_lvl_nx = free_lvl_q - LVL_W'(1);
		end
		if (do_release) begin
			free_lvl_nx = free_lvl_q + LVL_W'(1);
		end
		if (do_queue) begin
			pend_lvl_nx = pend_lvl_q + LVL_W'(1);
		end
		if (do_take) begin
			pend_lvl_nx = pend_lvl_q - LVL_W'(1);
		end
		low_nx  = (do_grab && free_lvl_nx < low_q) ? free_lvl_nx : low_q;
		high_nx = (do_queue && pend_lvl_nx > high_q) ? pend_lvl_nx : high_q;
	end

	// Request capture and response register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q.status           <= status;
			rsp_q.result_index     <= rindex;
			rsp_q.free_count       <= bpm_pkg::COUNT_W'(free_lvl_nx);
			rsp_q.pending_count    <= bpm_pkg::COUNT_W'(pend_lvl_nx);
			rsp_q.min_free_seen    <= bpm_pkg::COUNT_W'(low_nx);
			rsp_q.max_pending_seen <= bpm_pkg::COUNT_W'(high_nx);
		end
	end

	// Pending FIFO storage: only entries already pushed are ever read.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_queue) begin
			pend_mem_q[wrap_add(pend_rd_q, pend_lvl_q)] <= idx_low;
		end
	end

	// Free FIFO, state table, pointers, levels and watermarks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				free_mem_q[i] <= IDX_W'(i);
				state_q[i]    <= bpm_pkg::BUF_FREE;
			end
			free_rd_q  <= '0;
			pend_rd_q  <= '0;
			free_lvl_q <= LVL_W'(N);
			pend_lvl_q <= '0;
			low_q      <= LVL_W'(N);
			high_q     <= '0;
		end else if (cmd.commit) begin
			free_lvl_q <= free_lvl_nx;
			pend_lvl_q <= pend_lvl_nx;
			low_q      <= low_nx;
			high_q     <= high_nx;
			if (do_grab) begin
				free_rd_q          <= wrap_add(free_rd_q, LVL_W'(1));
				state_q[free_head] <= bpm_pkg::BUF_GRABBED;
			end
			if (do_queue) begin
				state_q[idx_low] <= bpm_pkg::BUF_PENDING;
			end
			if (do_take) begin
				pend_rd_q <= wrap_add(pend_rd_q, LVL_W'(1));
			end
			if (do_release) begin
				state_q[idx_low]                          <= bpm_pkg::BUF_FREE;
				free_mem_q[wrap_add(free_rd_q, free_lvl_q)] <= idx_low;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/core/buffer_pool_manager_core.sv
// Top level of the buffer pool manager core: controller plus datapath.
// Depends on bpm_pkg, bpm_ctrl and bpm_datapath.
//
// Each request transaction (grab, queue, take or release) yields exactly one response
// transaction carrying a status, an index and the current free and pending levels with
// their watermarks. The accepting edge captures the request; a later edge, once the
// response register is free or being emptied, checks and updates the FIFOs and the
// per-buffer state table, so a new request is accepted only after that execution.
// The response sits in an output register, so the next request is captured while it
// waits; execution of that request holds until the previous response has been taken. No
// clearing pass is needed after reset: requests are accepted from the first cycle.
module buffer_pool_manager_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bpm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bpm_pkg::rsp_t rsp
);

	bpm_pkg::ctrl_cmd_t cmd;

	// Sequencing of capture and execution.
	bpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Pool storage and operation logic.
	bpm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// File: rtl/core/bpm_checker.sv
// Port-level checker for the buffer pool manager core, bound to the top level.
// Depends on bpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bpm_pkg::rsp_t rsp
);

	// A stalled response transaction holds its payload.
	`BPM_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")

	// The free level never drops below its low watermark.
	`BPM_ASSERT(a_low_water, clk, arst_n, rsp_valid |-> rsp.min_free_seen <= rsp.free_count, "free level below low watermark")

	// The pending level never exceeds its high watermark.
	`BPM_ASSERT(a_high_water, clk, arst_n, rsp_valid |-> rsp.pending_count <= rsp.max_pending_seen, "pending level above high watermark")

	// No response is offered while reset is active.
	`BPM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !rsp_valid, "response valid during reset")

endmodule

bind buffer_pool_manager_core bpm_checker u_bpm_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for buffer_pool_manager_core: grab, queue, take and release traffic.
// Depends on bpm_pkg for the transaction types, operation codes, status codes and buffer states.
module testbench;

	localparam int NUM_BUFFERS = bpm_pkg::NUM_BUFFERS;
	localparam int INDEX_W     = bpm_pkg::INDEX_W;
	localparam int COUNT_W     = bpm_pkg::COUNT_W;

	localparam int RANDOM_OPS  = 1050;
	localparam int IDLE_PCT    = 32;
	localparam int HOLD_START  = 400;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LO    = 1500;
	localparam int QUIET_HI    = 2100;
	localparam int STUCK_LIMIT = 1000;
	localparam int TAIL_CYCLES = 10;

	// Shadow copy of the pool: both FIFOs, their levels and read slots, owners and watermarks.
	typedef struct packed {
		logic [NUM_BUFFERS-1:0][INDEX_W-1:0] free_q;
		logic [NUM_BUFFERS-1:0][INDEX_W-1:0] pend_q;
		int                                  free_lvl;
		int                                  pend_lvl;
		int                                  free_rd;
		int                                  pend_rd;
		logic [NUM_BUFFERS-1:0][1:0]         owner;
		int                                  low_water;
		int                                  high_water;
	} pool_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid = 1'b0;
	logic           req_stall;
	bpm_pkg::req_t  req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	bpm_pkg::rsp_t  rsp;

	bpm_pkg::req_t  op_backlog[$];
	bpm_pkg::rsp_t  awaited_rsp[$];
	pool_t          gen_pool;
	pool_t          model_pool;
	bpm_pkg::rsp_t  oldest_rsp;
	int             errors = 0;
	int             cycle_no = 0;
	int             stuck_run = 0;
	int             hold_left = 0;
	logic           quiet;

	buffer_pool_manager_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Free-running clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	assign quiet = (cycle_no >= QUIET_LO) && (cycle_no < QUIET_HI);

	// Pool state straight after reset: every index free, in order.
	function automatic pool_t pool_reset();
		pool_t p;
		p = '0;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			p.free_q[i] = INDEX_W'(i);
			p.owner[i]  = bpm_pkg::BUF_FREE;
		end
		p.free_lvl  = NUM_BUFFERS;
		p.low_water = NUM_BUFFERS;
		return p;
	endfunction

	// Applies one operation to a pool copy and returns the response it should give.
	function automatic bpm_pkg::rsp_t pool_step(inout pool_t p, input bpm_pkg::req_t r);
		bpm_pkg::rsp_t o;
		int   head;
		int   idx;
		int   slot;
		o    = '0;
		o.status = bpm_pkg::RES_OK;
		idx  = int'(r.buf_id);
		case (r.opcode)
			bpm_pkg::OP_GRAB: begin
				if (p.free_lvl == 0) begin
					o.status = bpm_pkg::RES_FREE_EMPTY;
				end else begin
					head = int'(p.free_q[p.free_rd]);
					o.result_index = INDEX_W'(head);
					if (head >= NUM_BUFFERS || p.owner[head] != bpm_pkg::BUF_FREE) begin
						o.status = bpm_pkg::RES_WRONG_STATE;
					end else begin
						p.free_rd = (p.free_rd + 1) % NUM_BUFFERS;
						p.free_lvl--;
						p.owner[head] = bpm_pkg::BUF_GRABBED;
						if (p.free_lvl < p.low_water)
							p.low_water = p.free_lvl;
					end
				end
			end
			bpm_pkg::OP_QUEUE: begin
				o.result_index = r.buf_id;
				if (idx >= NUM_BUFFERS) begin
					o.status = bpm_pkg::RES_RANGE;
				end else if (p.owner[idx] != bpm_pkg::BUF_GRABBED ||
						p.pend_lvl >= NUM_BUFFERS) begin
					o.status = bpm_pkg::RES_WRONG_STATE;
				end else begin
					p.owner[idx] = bpm_pkg::BUF_PENDING;
					slot = (p.pend_rd + p.pend_lvl) % NUM_BUFFERS;
					p.pend_q[slot] = r.buf_id;
					p.pend_lvl++;
					if (p.pend_lvl > p.high_water)
						p.high_water = p.pend_lvl;
				end
			end
			bpm_pkg::OP_TAKE: begin
				if (p.pend_lvl == 0) begin
					o.status = bpm_pkg::RES_PENDING_EMPTY;
				end else begin
					head = int'(p.pend_q[p.pend_rd]);
					o.result_index = INDEX_W'(head);
					if (head >= NUM_BUFFERS || p.owner[head] != bpm_pkg::BUF_PENDING) begin
						o.status = bpm_pkg::RES_WRONG_STATE;
					end else begin
						p.pend_rd = (p.pend_rd + 1) % NUM_BUFFERS;
						p.pend_lvl--;
					end
				end
			end
			default: begin
				o.result_index = r.buf_id;
				if (idx >= NUM_BUFFERS) begin
					o.status = bpm_pkg::RES_RANGE;
				end else if (p.owner[idx] != bpm_pkg::BUF_PENDING ||
						p.free_lvl >= NUM_BUFFERS) begin
					o.status = bpm_pkg::RES_WRONG_STATE;
				end else begin
					p.owner[idx] = bpm_pkg::BUF_FREE;
					slot = (p.free_rd + p.free_lvl) % NUM_BUFFERS;
					p.free_q[slot] = r.buf_id;
					p.free_lvl++;
				end
			end
		endcase
		o.free_count       = COUNT_W'(p.free_lvl);
		o.pending_count    = COUNT_W'(p.pend_lvl);
		o.min_free_seen    = COUNT_W'(p.low_water);
		o.max_pending_seen = COUNT_W'(p.high_water);
		return o;
	endfunction

	// A full pending FIFO whose head is no longer pending can never drain again.
	function automatic bit pool_jammed(pool_t p);
		return p.pend_lvl >= NUM_BUFFERS &&
			p.owner[p.pend_q[p.pend_rd]] != bpm_pkg::BUF_PENDING;
	endfunction

	// Random buffer in the given ownership state, or -1 when there is none.
	function automatic int pick_owned(pool_t p, logic [1:0] st);
		int cand[$];
		for (int i = 0; i < NUM_BUFFERS; i++)
			if (p.owner[i] == st)
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// Queues an operation for the driver unless it would jam the pending FIFO for good.
	function automatic bit try_schedule(bpm_pkg::req_t r);
		pool_t trial;
		trial  = gen_pool;
		void'(pool_step(trial, r));
		if (pool_jammed(trial))
			return 1'b0;
		gen_pool = trial;
		op_backlog.push_back(r);
		return 1'b1;
	endfunction

	task automatic schedule(bpm_pkg::opcode_t op, int idx);
		bpm_pkg::req_t r;
		r.opcode = op;
		r.buf_id = INDEX_W'(idx);
		void'(try_schedule(r));
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_no, msg);
		errors++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// Request driver: a new transaction is presented only once the previous one has gone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else if (!req_valid || !req_stall) begin
			if (op_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				req_valid <= 1'b1;
				req       <= op_backlog.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response receiver: random stalls, one long hold-off, and a quiet window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (cycle_no == HOLD_START) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Monitor: checks each accepted response, then predicts from each accepted request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					oldest_rsp = awaited_rsp.pop_front();
					check_field("status", int'(rsp.status), int'(oldest_rsp.status));
					check_field("result_index", int'(rsp.result_index),
						int'(oldest_rsp.result_index));
					check_field("free_count", int'(rsp.free_count),
						int'(oldest_rsp.free_count));
					check_field("pending_count", int'(rsp.pending_count),
						int'(oldest_rsp.pending_count));
					check_field("min_free_seen", int'(rsp.min_free_seen),
						int'(oldest_rsp.min_free_seen));
					check_field("max_pending_seen", int'(rsp.max_pending_seen),
						int'(oldest_rsp.max_pending_seen));
				end
			end
			if (req_valid && !req_stall)
				awaited_rsp.push_back(pool_step(model_pool, req));
		end
	end

	// Watchdog: ends the run if no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_no <= cycle_no + 1;
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				stuck_run <= 0;
			end else if (stuck_run >= STUCK_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				stuck_run <= stuck_run + 1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		bpm_pkg::req_t r;
		int   pick;
		// Reset goes low with an edge at time zero so that every register sees it.
		arst_n <= 1'b0;
		gen_pool   = pool_reset();
		model_pool = pool_reset();

		// Empty pending FIFO, release and queue of buffers in the wrong state.
		schedule(bpm_pkg::OP_TAKE, 0);
		schedule(bpm_pkg::OP_RELEASE, 0);
		schedule(bpm_pkg::OP_QUEUE, 0);
		// Drain the free FIFO, then grab once more from an empty pool.
		schedule(bpm_pkg::OP_GRAB, 255);
		schedule(bpm_pkg::OP_GRAB, 0);
		schedule(bpm_pkg::OP_GRAB, 170);
		schedule(bpm_pkg::OP_GRAB, 85);
		schedule(bpm_pkg::OP_GRAB, 0);
		// Indexes out of range.
		schedule(bpm_pkg::OP_QUEUE, 255);
		schedule(bpm_pkg::OP_RELEASE, NUM_BUFFERS);
		// Fill the pending FIFO.
		for (int i = 0; i < NUM_BUFFERS; i++)
			schedule(bpm_pkg::OP_QUEUE, i);
		// Release before take, re-grab, and queue into a full pending FIFO.
		schedule(bpm_pkg::OP_RELEASE, 1);
		schedule(bpm_pkg::OP_GRAB, 0);
		schedule(bpm_pkg::OP_QUEUE, 1);
		// The second take finds a head that is no longer pending.
		schedule(bpm_pkg::OP_TAKE, 255);
		schedule(bpm_pkg::OP_TAKE, 0);
		schedule(bpm_pkg::OP_QUEUE, 1);
		for (int i = 0; i <= NUM_BUFFERS; i++)
			schedule(bpm_pkg::OP_TAKE, 0);
		for (int i = 0; i < NUM_BUFFERS; i++)
			schedule(bpm_pkg::OP_RELEASE, i);

		// Random traffic, mostly well-formed with some noise indexes.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			do begin
				r.buf_id = INDEX_W'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				if (pick < 30)
					r.opcode = bpm_pkg::OP_GRAB;
				else if (pick < 55)
					r.opcode = bpm_pkg::OP_QUEUE;
				else if (pick < 80)
					r.opcode = bpm_pkg::OP_TAKE;
				else
					r.opcode = bpm_pkg::OP_RELEASE;
				if ($urandom_range(0, 99) < 80) begin
					pick = -1;
					if (r.opcode == bpm_pkg::OP_QUEUE)
						pick = pick_owned(gen_pool, bpm_pkg::BUF_GRABBED);
					else if (r.opcode == bpm_pkg::OP_RELEASE)
						pick = pick_owned(gen_pool, bpm_pkg::BUF_PENDING);
					if (pick >= 0)
						r.buf_id = INDEX_W'(pick);
				end
			end while (!try_schedule(r));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
